[rtl/khrgb_pkg.sv]
`timescale 1ns / 1ps

package khrgb_pkg;

  localparam int KEY_W        = 32;
  localparam int LEVEL_W      = 16;
  localparam int CNUM_W       = 20;
  localparam int BASE_W       = 21;
  localparam int PROD_W       = 36;
  localparam int FRONT_STAGES = 3;
  localparam int SCALE_STAGES = 5;
  localparam int NUM_STAGES   = FRONT_STAGES + SCALE_STAGES;

  localparam logic [LEVEL_W-1:0] HUE_FULL = 16'hffff;

  typedef logic [BASE_W-1:0]  base_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [LEVEL_W-1:0] level_t;

endpackage

[rtl/khrgb_front.sv]
`timescale 1ns / 1ps

module khrgb_front import khrgb_pkg::*; (
  input  logic                    clk,
  input  logic [FRONT_STAGES-1:0] en,
  input  logic [KEY_W-1:0]        color_key,
  output base_t                   base,
  output prod_t                   red_prod,
  output prod_t                   green_prod,
  output prod_t                   blue_prod
);

  localparam logic [15:0] SEC_B1 = 16'd10923;
  localparam logic [15:0] SEC_B2 = 16'd21845;
  localparam logic [15:0] SEC_B3 = 16'd32768;
  localparam logic [15:0] SEC_B4 = 16'd43690;
  localparam logic [15:0] SEC_B5 = 16'd54613;

  localparam logic [2:0] SEC_R_G  = 3'd0;
  localparam logic [2:0] SEC_G_R  = 3'd1;
  localparam logic [2:0] SEC_G_B  = 3'd2;
  localparam logic [2:0] SEC_B_G  = 3'd3;
  localparam logic [2:0] SEC_B_R  = 3'd4;
  localparam logic [2:0] SEC_R_B  = 3'd5;
  localparam logic [2:0] SEC_WRAP = 3'd6;

  logic [15:0] hue;
  logic [7:0]  sat;
  logic [7:0]  lig;
  logic [9:0]  lig4;

  logic [9:0]  s_sc_nxt, s_sc_r;
  logic [9:0]  l_sc_nxt, l_sc_r;
  logic [9:0]  a_sc_nxt, a_sc_r;
  logic [18:0] h6_nxt, h6_r;
  logic [2:0]  sec_raw_nxt, sec_raw_r;

  logic [18:0]       off;
  logic [18:0]       r_full;
  logic [17:0]       r_fold;
  logic [15:0]       t_nxt, t_r;
  logic [CNUM_W-1:0] c_nxt, c_r;
  logic [2:0]        sector_nxt, sector_r;
  logic [9:0]        l_sc_b_r;

  logic [15:0] k_red, k_green, k_blue;
  base_t       base_nxt, base_r;
  prod_t       red_nxt, red_r;
  prod_t       green_nxt, green_r;
  prod_t       blue_nxt, blue_r;

  // split key, scale fields, find hue sector
  always_comb begin
    hue  = color_key[15:0];
    sat  = color_key[23:16];
    lig  = color_key[31:24];
    lig4 = {lig, 2'b00};
    s_sc_nxt = {1'b0, sat, 1'b0} + 10'd255;
    l_sc_nxt = {1'b0, lig, 1'b0} + 10'd255;
    if (lig4 >= 10'd510) begin
      a_sc_nxt = 10'(11'd1530 - {1'b0, lig4});
    end else begin
      a_sc_nxt = 10'(11'd510 + {1'b0, lig4});
    end
    h6_nxt = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
    sec_raw_nxt = {2'b00, hue >= SEC_B1} + {2'b00, hue >= SEC_B2} +
                  {2'b00, hue >= SEC_B3} + {2'b00, hue >= SEC_B4} +
                  {2'b00, hue >= SEC_B5} + {2'b00, hue == HUE_FULL};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s_sc_r    <= s_sc_nxt;
      l_sc_r    <= l_sc_nxt;
      a_sc_r    <= a_sc_nxt;
      h6_r      <= h6_nxt;
      sec_raw_r <= sec_raw_nxt;
    end
  end

  // chroma and triangle weight
  always_comb begin
    case (sec_raw_r[2:1])
      2'd0:    off = 19'd0;
      2'd1:    off = 19'd131070;
      2'd2:    off = 19'd262140;
      default: off = 19'd393210;
    endcase
    r_full = h6_r - off;
    r_fold = r_full[17:0];
    if (r_fold >= 18'(HUE_FULL)) begin
      t_nxt = 16'(18'd131070 - r_fold);
    end else begin
      t_nxt = r_fold[15:0];
    end
    c_nxt      = CNUM_W'(a_sc_r) * CNUM_W'(s_sc_r);
    sector_nxt = (sec_raw_r == SEC_WRAP) ? SEC_R_G : sec_raw_r;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t_r      <= t_nxt;
      c_r      <= c_nxt;
      sector_r <= sector_nxt;
      l_sc_b_r <= l_sc_r;
    end
  end

  // per-channel weights and products
  always_comb begin
    k_red   = '0;
    k_green = '0;
    k_blue  = '0;
    case (sector_r)
      SEC_R_G: begin
        k_red   = HUE_FULL;
        k_green = t_r;
      end
      SEC_G_R: begin
        k_green = HUE_FULL;
        k_red   = t_r;
      end
      SEC_G_B: begin
        k_green = HUE_FULL;
        k_blue  = t_r;
      end
      SEC_B_G: begin
        k_blue  = HUE_FULL;
        k_green = t_r;
      end
      SEC_B_R: begin
        k_blue  = HUE_FULL;
        k_red   = t_r;
      end
      SEC_R_B: begin
        k_red   = HUE_FULL;
        k_blue  = t_r;
      end
      default: begin
        k_red   = '0;
      end
    endcase
    red_nxt   = PROD_W'(c_r) * PROD_W'(k_red);
    green_nxt = PROD_W'(c_r) * PROD_W'(k_green);
    blue_nxt  = PROD_W'(c_r) * PROD_W'(k_blue);
    base_nxt  = BASE_W'({l_sc_b_r, 11'b0}) - BASE_W'({l_sc_b_r, 3'b0}) - BASE_W'(c_r);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      base_r  <= base_nxt;
    end
  end

  assign base       = base_r;
  assign red_prod   = red_r;
  assign green_prod = green_r;
  assign blue_prod  = blue_r;

endmodule

[rtl/khrgb_scale.sv]
`timescale 1ns / 1ps

module khrgb_scale import khrgb_pkg::*; (
  input  logic                    clk,
  input  logic [SCALE_STAGES-1:0] en,
  input  base_t                   base,
  input  prod_t                   prod,
  output level_t                  level
);

  localparam logic [16:0] DIV_LO = 17'd65025;

  logic [37:0] v_sum;
  logic [31:0] w_nxt, w_r;

  logic [15:0] q0_nxt, q0_r;
  logic [24:0] r1_nxt, r1_r;

  logic [8:0]  q1;
  logic [16:0] qa_nxt, qa_r;
  logic [18:0] r2_nxt, r2_r;

  logic [2:0]  q2;
  logic [16:0] qb_nxt, qb_r;
  logic [16:0] r3_nxt, r3_r;

  logic [16:0] q_fin;
  level_t      level_nxt, level_r;

  // scaled component, then drop the power-of-two part of the divisor
  always_comb begin
    v_sum = {1'b0, base, 16'b0} - 38'(base) + {1'b0, prod, 1'b0};
    w_nxt = v_sum[36:5];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      w_r <= w_nxt;
    end
  end

  // divide by 65025 = 65536 - 511: fold the high part back three times
  always_comb begin
    q0_nxt = w_r[31:16];
    r1_nxt = 25'({q0_nxt, 9'b0}) - 25'(q0_nxt) + 25'(w_r[15:0]);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      q0_r <= q0_nxt;
      r1_r <= r1_nxt;
    end
  end

  always_comb begin
    q1     = r1_r[24:16];
    r2_nxt = 19'({q1, 9'b0}) - 19'(q1) + 19'(r1_r[15:0]);
    qa_nxt = 17'(q0_r) + 17'(q1);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      qa_r <= qa_nxt;
      r2_r <= r2_nxt;
    end
  end

  always_comb begin
    q2     = r2_r[18:16];
    r3_nxt = 17'({q2, 9'b0}) - 17'(q2) + 17'(r2_r[15:0]);
    qb_nxt = qa_r + 17'(q2);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      qb_r <= qb_nxt;
      r3_r <= r3_nxt;
    end
  end

  always_comb begin
    q_fin     = (r3_r >= DIV_LO) ? qb_r + 17'd1 : qb_r;
    level_nxt = q_fin[LEVEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

endmodule

[rtl/key_to_hsl_to_rgb_color.sv]
`timescale 1ns / 1ps

// Converts a 32-bit color key (hue in bits 15:0, saturation in 23:16, lightness
// in 31:24) to 16-bit red, green and blue levels through the HSL-to-RGB
// conversion, with saturation and lightness squeezed into 0.25..0.75. The
// block takes one word per clock when back-pressure does not stall it: three
// stages form chroma, hue weight and the per-channel products, five more per
// channel build the scaled sum and divide it by a constant through
// shift-and-fold steps. Every stage holds its own valid bit and stalls only
// when it is full and the stage after it cannot advance, so back-pressure on
// the output fills empty stages before it reaches the input.

module key_to_hsl_to_rgb_color import khrgb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] color_key
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [15:0] red_level, [31:16] green_level, [47:32] blue_level
);

  logic [NUM_STAGES:0]   en;
  logic [NUM_STAGES-1:0] v_in;
  logic [NUM_STAGES-1:0] v_nxt, v_r;

  base_t  base;
  prod_t  red_prod, green_prod, blue_prod;
  level_t red_level, green_level, blue_level;

  // a stage advances when it is empty or the next one advances
  always_comb begin
    en[NUM_STAGES] = out_tready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_in = {v_r[NUM_STAGES-2:0], in_tvalid};
    v_nxt = v_r;
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (en[i]) begin
        v_nxt[i] = v_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  khrgb_front u_front (
    .clk        (clk),
    .en         (en[FRONT_STAGES-1:0]),
    .color_key  (in_tdata),
    .base       (base),
    .red_prod   (red_prod),
    .green_prod (green_prod),
    .blue_prod  (blue_prod)
  );

  khrgb_scale u_scale_red (
    .clk   (clk),
    .en    (en[NUM_STAGES-1:FRONT_STAGES]),
    .base  (base),
    .prod  (red_prod),
    .level (red_level)
  );

  khrgb_scale u_scale_green (
    .clk   (clk),
    .en    (en[NUM_STAGES-1:FRONT_STAGES]),
    .base  (base),
    .prod  (green_prod),
    .level (green_level)
  );

  khrgb_scale u_scale_blue (
    .clk   (clk),
    .en    (en[NUM_STAGES-1:FRONT_STAGES]),
    .base  (base),
    .prod  (blue_prod),
    .level (blue_level)
  );

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NUM_STAGES-1];
  assign out_tdata  = {blue_level, green_level, red_level};

endmodule

[sim/key_to_hsl_to_rgb_color_tb.sv]
`timescale 1ns / 1ps

module key_to_hsl_to_rgb_color_tb;
  import khrgb_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int PIPE_DRAIN  = NUM_STAGES + 8;
  localparam int HOLD_CYCLES = 64;
  localparam int LEV_SCALE   = 1020;
  localparam int LEV_MID     = 510;
  localparam longint unsigned OUT_DIV = 2 * LEV_SCALE * LEV_SCALE;

  localparam logic [KEY_W-1:0] DIRECTED_KEYS [22] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_0000, 32'h00FF_0000,
    32'h80FF_FFFF, 32'h80FF_0000, 32'h80FF_2AAA, 32'h80FF_2AAB,
    32'h80FF_5554, 32'h80FF_5555, 32'h80FF_7FFF, 32'h80FF_8000,
    32'h80FF_AAA9, 32'h80FF_AAAA, 32'h80FF_D554, 32'h80FF_D555,
    32'h7F80_FFFE, 32'h7F7F_1234, 32'h0100_0001, 32'hFE01_C000,
    32'h55AA_AA55, 32'hAA55_55AA
  };

  typedef struct packed {
    level_t blue;
    level_t green;
    level_t red;
  } rgb_word_t;

  typedef enum int {
    SECTOR_RED_YELLOW,
    SECTOR_YELLOW_GREEN,
    SECTOR_GREEN_CYAN,
    SECTOR_CYAN_BLUE,
    SECTOR_BLUE_MAGENTA,
    SECTOR_MAGENTA_RED
  } hue_sector_e;

  class rgb_scoreboard;
    rgb_word_t        expected_rgb[$];
    logic [KEY_W-1:0] expected_key[$];
    int               mismatches = 0;
    int               checked    = 0;

    function rgb_word_t predict_rgb(logic [KEY_W-1:0] key);
      longint unsigned hue, sat, lig, s_sc, l_sc, a_sc, chroma;
      longint unsigned h6, sect_num, ramp, weight, c_v, x_v, m_v, r_v, g_v, b_v;
      hue_sector_e     sector;
      rgb_word_t       res;
      hue  = 64'(key[15:0]);
      sat  = 64'(key[23:16]);
      lig  = 64'(key[31:24]);
      s_sc = 2 * sat + 255;
      l_sc = 2 * lig + 255;
      a_sc = (4 * lig > LEV_MID) ? LEV_SCALE - (4 * lig - LEV_MID)
                                 : LEV_SCALE - (LEV_MID - 4 * lig);
      chroma   = a_sc * s_sc;
      h6       = 6 * hue;
      sect_num = h6 / HUE_FULL;
      ramp     = h6 % (2 * longint'(HUE_FULL));
      weight   = (ramp > HUE_FULL) ? HUE_FULL - (ramp - HUE_FULL)
                                   : HUE_FULL - (HUE_FULL - ramp);
      c_v = chroma * HUE_FULL * 2;
      x_v = chroma * weight * 2;
      m_v = l_sc * LEV_SCALE * HUE_FULL * 2 - chroma * HUE_FULL;
      r_v = m_v;
      g_v = m_v;
      b_v = m_v;
      // wrap full-scale hue onto the first sector
      if (sect_num >= 6) sect_num = 0;
      sector = hue_sector_e'(sect_num);
      case (sector)
        SECTOR_RED_YELLOW: begin
          r_v += c_v; g_v += x_v;
        end
        SECTOR_YELLOW_GREEN: begin
          g_v += c_v; r_v += x_v;
        end
        SECTOR_GREEN_CYAN: begin
          g_v += c_v; b_v += x_v;
        end
        SECTOR_CYAN_BLUE: begin
          b_v += c_v; g_v += x_v;
        end
        SECTOR_BLUE_MAGENTA: begin
          b_v += c_v; r_v += x_v;
        end
        default: begin
          r_v += c_v; b_v += x_v;
        end
      endcase
      res.red   = level_t'(r_v / OUT_DIV);
      res.green = level_t'(g_v / OUT_DIV);
      res.blue  = level_t'(b_v / OUT_DIV);
      return res;
    endfunction

    function void note_key(logic [KEY_W-1:0] key);
      expected_rgb.push_back(predict_rgb(key));
      expected_key.push_back(key);
    endfunction

    function int pending();
      return expected_rgb.size();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_word(rgb_word_t got);
      rgb_word_t        want;
      logic [KEY_W-1:0] key;
      if (expected_rgb.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", got));
        return;
      end
      want = expected_rgb.pop_front();
      key  = expected_key.pop_front();
      checked++;
      if (got.red !== want.red)
        report_mismatch($sformatf("key %h red %h, want %h", key, got.red, want.red));
      if (got.green !== want.green)
        report_mismatch($sformatf("key %h green %h, want %h", key, got.green, want.green));
      if (got.blue !== want.blue)
        report_mismatch($sformatf("key %h blue %h, want %h", key, got.blue, want.blue));
    endtask
  endclass

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic [KEY_W-1:0] in_tdata   = '0;
  logic             in_tready;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [47:0]      out_tdata;

  int send_idle_pct   = 9;
  int recv_idle_pct   = 59;
  int recv_hold_left  = 0;
  int keys_sent       = 0;
  int in_stall_cycles = 0;

  rgb_scoreboard color_sb = new();

  key_to_hsl_to_rgb_color i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic [KEY_W-1:0] random_key();
    logic [15:0] hue;
    logic [7:0]  sat, lig;
    int unsigned mode, sect_bound;
    mode = $urandom_range(0, 9);
    hue  = 16'($urandom);
    sat  = 8'($urandom);
    lig  = 8'($urandom);
    case (mode)
      6: begin
        sect_bound = ($urandom_range(1, 6) * 65535 + 5) / 6;
        hue = 16'(sect_bound - 1 + $urandom_range(0, 2));
      end
      7: begin
        sat = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        lig = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      8: hue = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      9: begin
        hue = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        sat = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        lig = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: ;
    endcase
    return {lig, sat, hue};
  endfunction

  task automatic send_key(input logic [KEY_W-1:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    do begin
      @(posedge clk);
      if (!in_tready) in_stall_cycles++;
    end while (!in_tready);
    color_sb.note_key(key);
    keys_sent++;
  endtask

  task automatic wait_all_results();
    while (color_sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) color_sb.check_word(out_tdata);
      if (recv_hold_left > 0) begin
        out_tready <= 1'b0;
        recv_hold_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_KEYS[i]) send_key(DIRECTED_KEYS[i]);
    repeat (300) send_key(random_key());
    // drain before swapping idle profiles
    in_tvalid <= 1'b0;
    wait_all_results();

    send_idle_pct = 59;
    recv_idle_pct = 9;
    repeat (300) send_key(random_key());

    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    recv_hold_left = HOLD_CYCLES;
    repeat (250) send_key(random_key());
    in_tvalid <= 1'b0;

    wait_all_results();
    repeat (PIPE_DRAIN) @(posedge clk);

    $display("summary: %0d keys sent under three idle profiles and a %0d-cycle output hold",
             keys_sent, HOLD_CYCLES);
    $display("summary: %0d words checked, %0d input stall cycles, %0d mismatches",
             color_sb.checked, in_stall_cycles, color_sb.mismatches);
    if (color_sb.mismatches == 0) begin
      $display("[key_to_hsl_to_rgb_color] OK");
    end else begin
      $display("[key_to_hsl_to_rgb_color] ERROR");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 250000);
    $display("timeout with %0d words outstanding", color_sb.pending());
    $display("[key_to_hsl_to_rgb_color] ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/khrgb_pkg.sv
rtl/khrgb_front.sv
rtl/khrgb_scale.sv
rtl/key_to_hsl_to_rgb_color.sv
sim/key_to_hsl_to_rgb_color_tb.sv
